// ===== sv/pcts_pkg.sv =====
`default_nettype none

package pcts_pkg;

  localparam int IDX_W       = 5;
  localparam int PRIO_W      = 8;
  localparam int ROW_W       = 32;
  localparam int MAX_ENTRIES = 32;
  localparam int LEAVES      = 32;
  localparam int LEVELS      = 5;
  localparam int SETTLE_W    = 3;

  typedef enum logic [1:0] {
    OP_LOAD_ROW  = 2'd0,
    OP_LOAD_PRIO = 2'd1,
    OP_MARK      = 2'd2,
    OP_COMPUTE   = 2'd3
  } op_e;

  typedef struct packed {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [IDX_W-1:0]         idx;
  } node_t;

  typedef struct packed {
    logic wr_row;
    logic wr_prio;
    logic mark;
    logic union_start;
    logic union_step;
    logic clear_marks;
    logic restart;
    logic emit;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic union_done;
    logic pending_empty;
    logic settled;
    logic out_free;
    logic last_pick;
  } sts_t;

  // Left child always has the lower index, so ties stay on the left.
  function automatic node_t pick(input node_t a, input node_t b);
    if (b.valid && (!a.valid || (b.prio > a.prio))) begin
      return b;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pcts_ctrl.sv =====
`default_nettype none

module pcts_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [1:0]       operation_i,
  output logic                  in_ready_o,
  input  wire pcts_pkg::sts_t   sts_i,
  output pcts_pkg::cmd_t        cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UNION  = 5'b00010,
    S_CHECK  = 5'b00100,
    S_EMPTY  = 5'b01000,
    S_SELECT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (pcts_pkg::op_e'(operation_i))
            pcts_pkg::OP_LOAD_ROW:  cmd_o.wr_row  = 1'b1;
            pcts_pkg::OP_LOAD_PRIO: cmd_o.wr_prio = 1'b1;
            pcts_pkg::OP_MARK:      cmd_o.mark    = 1'b1;
            pcts_pkg::OP_COMPUTE: begin
              cmd_o.union_start = 1'b1;
              state_d           = S_UNION;
            end
          endcase
        end
      end
      S_UNION: begin
        cmd_o.union_step = 1'b1;
        if (sts_i.union_done) begin
          cmd_o.clear_marks = 1'b1;
          cmd_o.restart     = 1'b1;
          state_d           = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = sts_i.pending_empty ? S_EMPTY : S_SELECT;
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_SELECT: begin
        // hold until the tree has settled on the current pending set
        if (sts_i.settled && sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.restart = 1'b1;
          if (sts_i.last_pick) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcts_datapath.sv =====
`default_nettype none

module pcts_datapath #(
  parameter int PLACES = 32,
  parameter int TRANS  = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire pcts_pkg::cmd_t                        cmd_i,
  output pcts_pkg::sts_t                             sts_o,
  input  wire logic [pcts_pkg::IDX_W-1:0]            place_index_i,
  input  wire logic [pcts_pkg::IDX_W-1:0]            transition_index_i,
  input  wire logic [pcts_pkg::ROW_W-1:0]            row_mask_i,
  input  wire logic signed [pcts_pkg::PRIO_W-1:0]    priority_value_i,
  input  wire logic                                  out_ready_i,
  output logic                                       out_valid_o,
  output logic [pcts_pkg::IDX_W-1:0]                 candidate_o,
  output logic signed [pcts_pkg::PRIO_W-1:0]         candidate_priority_o,
  output logic                                       empty_res_o,
  output logic                                       last_o
);

  localparam int PW = (PLACES > 1) ? $clog2(PLACES) : 1;
  localparam int TW = (TRANS > 1) ? $clog2(TRANS) : 1;

  logic [TRANS-1:0]                   rows_q [PLACES];
  logic signed [pcts_pkg::PRIO_W-1:0] prio_q [TRANS];
  logic [PLACES-1:0]                  marks_q;
  logic [TRANS-1:0]                   pending_q;
  logic [PW-1:0]                      place_q;
  logic [pcts_pkg::SETTLE_W-1:0]      settle_q;
  logic                               out_valid_q;

  pcts_pkg::node_t leaf_n [pcts_pkg::LEAVES];
  pcts_pkg::node_t node_q [1:pcts_pkg::LEAVES-1];
  pcts_pkg::node_t root_n;

  logic             place_ok;
  logic             trans_ok;
  logic [TRANS-1:0] pick_bit;
  logic [TRANS-1:0] pending_left;

  assign place_ok = ({1'b0, place_index_i} < (pcts_pkg::IDX_W + 1)'(PLACES));
  assign trans_ok = ({1'b0, transition_index_i} < (pcts_pkg::IDX_W + 1)'(TRANS));

  assign root_n       = node_q[1];
  assign pick_bit     = TRANS'(1) << root_n.idx;
  assign pending_left = pending_q & ~pick_bit;

  assign sts_o.union_done    = (place_q == PW'(PLACES - 1));
  assign sts_o.pending_empty = (pending_q == '0);
  assign sts_o.settled       = (settle_q == pcts_pkg::SETTLE_W'(pcts_pkg::LEVELS));
  assign sts_o.out_free      = !out_valid_q || out_ready_i;
  assign sts_o.last_pick     = (pending_left == '0);

  // Leaves beyond the transition count never compete.
  for (genvar t = 0; t < pcts_pkg::LEAVES; t++) begin : g_leaf
    if (t < TRANS) begin : g_used
      assign leaf_n[t] = '{valid: pending_q[t], prio: prio_q[t],
                           idx: pcts_pkg::IDX_W'(t)};
    end else begin : g_pad
      assign leaf_n[t] = '{valid: 1'b0, prio: '0, idx: '0};
    end
  end

  // Heap-ordered max tree, one register per node.
  for (genvar n = 1; n < pcts_pkg::LEAVES; n++) begin : g_node
    if (n >= pcts_pkg::LEAVES / 2) begin : g_bottom
      always_ff @(posedge clk_i) begin
        node_q[n] <= pcts_pkg::pick(leaf_n[2*n - pcts_pkg::LEAVES],
                                    leaf_n[2*n - pcts_pkg::LEAVES + 1]);
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        node_q[n] <= pcts_pkg::pick(node_q[2*n], node_q[2*n + 1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLACES; p++) begin
        rows_q[p] <= '0;
      end
      for (int t = 0; t < TRANS; t++) begin
        prio_q[t] <= '0;
      end
      marks_q     <= '0;
      pending_q   <= '0;
      place_q     <= '0;
      settle_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_row && place_ok) begin
        rows_q[place_index_i[PW-1:0]] <= row_mask_i[TRANS-1:0];
      end
      if (cmd_i.wr_prio && trans_ok) begin
        prio_q[transition_index_i[TW-1:0]] <= priority_value_i;
      end
      if (cmd_i.clear_marks) begin
        marks_q <= '0;
      end else if (cmd_i.mark && place_ok) begin
        marks_q[place_index_i[PW-1:0]] <= 1'b1;
      end

      if (cmd_i.union_start) begin
        pending_q <= '0;
        place_q   <= '0;
      end else if (cmd_i.union_step) begin
        if (marks_q[place_q]) begin
          pending_q <= pending_q | rows_q[place_q];
        end
        if (!sts_o.union_done) begin
          place_q <= place_q + PW'(1);
        end
      end else if (cmd_i.emit) begin
        pending_q <= pending_left;
      end

      // settle counter: cleared on each restart, when pending last changed, and saturating at the tree depth
      if (cmd_i.restart) begin
        settle_q <= '0;
      end else if (!sts_o.settled) begin
        settle_q <= settle_q + pcts_pkg::SETTLE_W'(1);
      end

      if (cmd_i.emit || cmd_i.emit_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      candidate_o          <= root_n.idx;
      candidate_priority_o <= root_n.prio;
      empty_res_o          <= 1'b0;
      last_o               <= sts_o.last_pick;
    end else if (cmd_i.emit_empty) begin
      candidate_o          <= '0;
      candidate_priority_o <= '0;
      empty_res_o          <= 1'b1;
      last_o               <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/petri_candidate_transition_sorter_unit.sv =====
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid_i/in_ready_o  operation_i, place_index_i, transition_index_i,
//                                  row_mask_i, priority_value_i
// out       out_valid_o/out_ready_i candidate_o, candidate_priority_o, empty_res_o,
//                                  last_o
//
// Load and mark transactions are written as they are accepted, in the idle state.
// Compute: an accept, the union state ORs the marked rows into the pending set (one row per cycle),
// then a check state; each candidate is emitted once the 5-level registered max tree has settled
// on the pending set and the output slot is free.
// An empty union gives its single result from the empty state once the output slot is free.
// rst_ni clears all tables, marks and control state at once; no clearing pass.
// A stalled output holds the next selection; loads wait until a compute finishes.
module petri_candidate_transition_sorter_unit #(
  parameter int NUM_PLACES      = 32,
  parameter int NUM_TRANSITIONS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          operation_i,
  input  wire logic [pcts_pkg::IDX_W-1:0]          place_index_i,
  input  wire logic [pcts_pkg::IDX_W-1:0]          transition_index_i,
  input  wire logic [pcts_pkg::ROW_W-1:0]          row_mask_i,
  input  wire logic signed [pcts_pkg::PRIO_W-1:0]  priority_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [pcts_pkg::IDX_W-1:0]               candidate_o,
  output logic signed [pcts_pkg::PRIO_W-1:0]       candidate_priority_o,
  output logic                                     empty_res_o,
  output logic                                     last_o
);

  localparam int PLACES = (NUM_PLACES > pcts_pkg::MAX_ENTRIES) ?
                          pcts_pkg::MAX_ENTRIES : NUM_PLACES;
  localparam int TRANS  = (NUM_TRANSITIONS > pcts_pkg::MAX_ENTRIES) ?
                          pcts_pkg::MAX_ENTRIES : NUM_TRANSITIONS;

  pcts_pkg::cmd_t cmd;
  pcts_pkg::sts_t sts;

  pcts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .operation_i(operation_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcts_datapath #(
    .PLACES(PLACES),
    .TRANS (TRANS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .place_index_i       (place_index_i),
    .transition_index_i  (transition_index_i),
    .row_mask_i          (row_mask_i),
    .priority_value_i    (priority_value_i),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .candidate_o         (candidate_o),
    .candidate_priority_o(candidate_priority_o),
    .empty_res_o         (empty_res_o),
    .last_o              (last_o)
  );

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_o && (candidate_o == '0) &&
                                   (candidate_priority_o == '0))
    else $error("empty result must be a zeroed final transaction");

  a_compute_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (operation_i == pcts_pkg::OP_COMPUTE) |=> !in_ready_o)
    else $error("input accepted right after a compute transaction");

  a_mid_list_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready while a candidate list is still open");

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit || cmd.emit_empty) |-> (!out_valid_o || out_ready_i))
    else $error("result written over an unaccepted transaction");

endmodule

`default_nettype wire
